// ----- hdl/tlbat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tlbat_pkg;
   localparam int TlbEntries = 48;
   localparam int IdxW = 6;
   localparam logic [31:0] PageMaskBits = 32'h01FF_E000;
   localparam logic [31:0] PageOffsetBits = 32'h0000_0FFF;
   localparam logic [31:0] VpnBits = 32'hFFFF_F000;
   localparam logic [31:0] DirectBits = 32'h1FFF_FFFF;
   localparam logic [31:0] SegDirectLo = 32'h8000_0000;
   localparam logic [31:0] SegMappedLo = 32'hC000_0000;
   localparam logic [31:0] ScratchBaseReset = 32'h7000_0000;
   localparam logic [20:0] ScratchSizeReset = 21'h004000;

   typedef enum logic [1:0] {
      KIND_TRANSLATE = 2'd0,
      KIND_PROBE     = 2'd1,
      KIND_READ      = 2'd2,
      KIND_WRITE     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ROUTE_DIRECT = 2'd0,
      ROUTE_LOOKUP = 2'd1,
      ROUTE_RANGE  = 2'd2
   } route_type;

   localparam logic CSR_SCRATCH_BASE = 1'b0;
   localparam logic CSR_SCRATCH_SIZE = 1'b1;

   // Classified command handed from front to back.
   typedef struct packed {
      kind_type    kind;
      route_type   route;
      logic [31:0] addr;     // direct phys result or lookup address
      logic [IdxW-1:0] idx;
      logic [31:0] vpn;
      logic [19:0] pfn;
      logic [31:0] mask;
      logic        valid;
   } cmd_type;
endpackage
`default_nettype wire

// ----- hdl/tlbat_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tlbat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] virt_addr;
   logic [5:0]  entry_index;
   logic [31:0] vpn_key;
   logic [31:0] entry_pfn;
   logic [31:0] entry_mask;
   logic        entry_valid;
   modport source (output valid, kind, virt_addr, entry_index, vpn_key, entry_pfn,
                   entry_mask, entry_valid, input ready);
   modport sink (input valid, kind, virt_addr, entry_index, vpn_key, entry_pfn,
                 entry_mask, entry_valid, output ready);
endinterface
`default_nettype wire

// ----- hdl/tlbat_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tlbat_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] phys_addr;
   logic [5:0]  hit_index;
   logic [31:0] rd_vpn;
   logic [19:0] rd_pfn;
   logic [24:0] rd_mask;
   logic        rd_valid;
   modport source (output valid, status, phys_addr, hit_index, rd_vpn, rd_pfn, rd_mask,
                   rd_valid, input ready);
   modport sink (input valid, status, phys_addr, hit_index, rd_vpn, rd_pfn, rd_mask,
                 rd_valid, output ready);
endinterface
`default_nettype wire

// ----- hdl/tlbat_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Classifies a request: window, segment map, or TLB lookup; range checks.
module tlbat_front (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   tlbat_req_if.sink        req,
   output tlbat_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  wire logic        cmd_ready
);
   logic [31:0] base_ff, base_in;
   logic [20:0] size_ff, size_in;
   logic [32:0] top;
   logic [31:0] va;
   tlbat_pkg::cmd_type c;

   // Config registers
   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (csr_we) begin
         unique case (csr_index)
            tlbat_pkg::CSR_SCRATCH_BASE: base_in = csr_wdata;
            tlbat_pkg::CSR_SCRATCH_SIZE: size_in = csr_wdata[20:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= tlbat_pkg::ScratchBaseReset;
         size_ff <= tlbat_pkg::ScratchSizeReset;
      end else begin
         base_ff <= base_in;
         size_ff <= size_in;
      end
   end

   // Classification
   always_comb begin
      va = req.virt_addr;
      top = {1'b0, base_ff} + {12'd0, size_ff};
      c.kind = tlbat_pkg::kind_type'(req.kind);
      c.route = tlbat_pkg::ROUTE_DIRECT;
      c.addr = 32'd0;
      c.idx = req.entry_index;
      c.vpn = req.vpn_key & tlbat_pkg::VpnBits;
      c.pfn = req.entry_pfn[19:0];
      c.mask = req.entry_mask & tlbat_pkg::PageMaskBits;
      c.valid = req.entry_valid;
      case (c.kind)
         tlbat_pkg::KIND_TRANSLATE: begin
            if (va >= base_ff && {1'b0, va} < top) c.addr = va - base_ff;
            else if (va >= tlbat_pkg::SegMappedLo) begin
               c.route = tlbat_pkg::ROUTE_LOOKUP;
               c.addr = va;
            end else if (va >= tlbat_pkg::SegDirectLo) c.addr = va & tlbat_pkg::DirectBits;
            else c.addr = va;
         end
         tlbat_pkg::KIND_PROBE: begin
            c.route = tlbat_pkg::ROUTE_LOOKUP;
            c.addr = c.vpn;
         end
         default: begin
            if (req.entry_index >= tlbat_pkg::IdxW'(tlbat_pkg::TlbEntries))
               c.route = tlbat_pkg::ROUTE_RANGE;
         end
      endcase
   end

   // Two-entry queue to the back end
   tlbat_pkg::cmd_type q_ff [2];
   tlbat_pkg::cmd_type q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;
   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];
   always_comb cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end

   // Shift on pop, new entry lands in the first free slot
   always_comb begin
      q0_in = q_ff[0];
      q1_in = q_ff[1];
      if (pop) q0_in = q_ff[1];
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) q0_in = c;
         else q1_in = c;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req.ready) else $error("ready while full");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && cnt_ff == 2'd0) |=> cmd_valid) else $error("lost push");
endmodule
`default_nettype wire

// ----- hdl/tlbat_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Executes commands against the entry table; one result register.
module tlbat_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  tlbat_pkg::cmd_type cmd,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   tlbat_rsp_if.source      rsp
);
   localparam int N = tlbat_pkg::TlbEntries;
   logic [19:0] vpn_ff [N];
   logic [19:0] pfn_ff [N];
   logic [11:0] msk_ff [N];
   logic [N-1:0] val_ff;

   logic take;
   logic hit;
   logic [tlbat_pkg::IdxW-1:0] hidx;
   logic [N-1:0] match;
   logic [31:0] off, phys;
   logic [1:0] st;
   logic out_valid_ff;
   logic [1:0] st_ff;
   logic [31:0] phys_ff, rvpn_ff;
   logic [5:0] hit_ff;
   logic [19:0] rpfn_ff;
   logic [24:0] rmask_ff;
   logic rval_ff;
   logic [31:0] phys_in, rvpn_in;
   logic [5:0] hit_in;
   logic [19:0] rpfn_in;
   logic [24:0] rmask_in;
   logic rval_in;

   assign cmd_ready = !out_valid_ff || rsp.ready;
   assign take = cmd_valid && cmd_ready;

   // Parallel compare with priority pick
   always_comb begin
      for (int i = 0; i < N; i++) begin
         match[i] = val_ff[i] &&
            ((({cmd.addr[31:12]} ^ vpn_ff[i]) & ~{7'd0, msk_ff[i], 1'b0}) == 20'd0);
      end
      hit = |match;
      hidx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match[i]) hidx = tlbat_pkg::IdxW'(i);
      end
      // offset range: mask bits 24..13 plus the 12-bit page offset
      off = {7'd0, msk_ff[hidx], 13'h0FFF};
      phys = ({pfn_ff[hidx], 12'd0} & ~off) | (cmd.addr & off);
   end

   // Table writes
   always_ff @(posedge clock) begin
      if (reset) val_ff <= '0;
      else if (take && cmd.kind == tlbat_pkg::KIND_WRITE &&
               cmd.route != tlbat_pkg::ROUTE_RANGE)
         val_ff[cmd.idx] <= cmd.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            vpn_ff[i] <= '0;
            pfn_ff[i] <= '0;
            msk_ff[i] <= '0;
         end
      end else if (take && cmd.kind == tlbat_pkg::KIND_WRITE &&
                   cmd.route != tlbat_pkg::ROUTE_RANGE) begin
         vpn_ff[cmd.idx] <= cmd.vpn[31:12];
         pfn_ff[cmd.idx] <= cmd.pfn;
         msk_ff[cmd.idx] <= cmd.mask[24:13];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (take) out_valid_ff <= 1'b1;
      else if (rsp.ready) out_valid_ff <= 1'b0;
   end

   always_comb begin
      st = tlbat_pkg::ST_OK;
      if (cmd.route == tlbat_pkg::ROUTE_RANGE) st = tlbat_pkg::ST_RANGE;
      else if (cmd.route == tlbat_pkg::ROUTE_LOOKUP && !hit) st = tlbat_pkg::ST_MISS;
   end

   // Result fields; anything a request does not produce stays zero
   always_comb begin
      phys_in = '0;
      hit_in = '0;
      rvpn_in = '0;
      rpfn_in = '0;
      rmask_in = '0;
      rval_in = 1'b0;
      case (cmd.kind)
         tlbat_pkg::KIND_TRANSLATE: begin
            if (cmd.route == tlbat_pkg::ROUTE_DIRECT) phys_in = cmd.addr;
            else if (hit) phys_in = phys;
         end
         tlbat_pkg::KIND_PROBE: if (hit) hit_in = hidx;
         tlbat_pkg::KIND_READ: begin
            if (cmd.route != tlbat_pkg::ROUTE_RANGE) begin
               rvpn_in = {vpn_ff[cmd.idx], 12'd0};
               rpfn_in = pfn_ff[cmd.idx];
               rmask_in = {msk_ff[cmd.idx], 13'd0};
               rval_in = val_ff[cmd.idx];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) begin
         st_ff <= st;
         phys_ff <= phys_in;
         hit_ff <= hit_in;
         rvpn_ff <= rvpn_in;
         rpfn_ff <= rpfn_in;
         rmask_ff <= rmask_in;
         rval_ff <= rval_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.status = st_ff;
   assign rsp.phys_addr = phys_ff;
   assign rsp.hit_index = hit_ff;
   assign rsp.rd_vpn = rvpn_ff;
   assign rsp.rd_pfn = rpfn_ff;
   assign rsp.rd_mask = rmask_ff;
   assign rsp.rd_valid = rval_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
   a_take: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp.valid) else $error("no result after transfer");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

// ----- hdl/tlb_address_translator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// TLB address translator.
// req channel: one request per transfer (translate, probe, read, write).
// rsp channel: exactly one result per request, in request order.
// csr port: csr_we/csr_index/csr_wdata set the scratchpad base (0) and size (1);
// write only while no request is in flight.
// The front end classifies a request (window, direct segment, TLB lookup,
// index range check) and pushes it into a two-entry queue. The back end
// compares all 48 entries in parallel and registers the result.
// Each request passes through the queue and then the result register before
// its result is valid on rsp.
// Throughput: one request per cycle while rsp is ready.
// Reset clears every entry (all fields zero, invalid) and restores the
// register defaults. When rsp stalls, the result register holds,
// the queue fills, and req.ready drops once two requests are queued.
module tlb_address_translator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   tlbat_req_if.sink        req,
   tlbat_rsp_if.source      rsp
);
   tlbat_pkg::cmd_type cmd;
   logic cmd_valid, cmd_ready;

   tlbat_front u_front (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req(req), .cmd(cmd), .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready)
   );

   tlbat_back u_back (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready), .rsp(rsp)
   );
endmodule
`default_nettype wire
